>>> rtl/epmat_pkg.sv
// ----------------------------------------------------------------------------
// epmat_pkg
// Shared widths, constants and types of the edge-period tachometer.
// ----------------------------------------------------------------------------
package epmat_pkg;

    // Field widths.
    localparam int TIME_W    = 32;
    localparam int RPM_W     = 26;
    localparam int MINP_W    = 24;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 64;

    // Reset value of the minimum-period register, in microseconds.
    localparam logic [MINP_W-1:0] MINP_RESET = 24'd150000;

    // Microseconds per minute: the dividend of the speed computation.
    localparam logic [RPM_W-1:0] RPM_NUM = 26'd60000000;

    // Microsecond timestamps, periods and averages.
    typedef logic [TIME_W-1:0] period_t;

    // Speed in revolutions per minute.
    typedef logic [RPM_W-1:0] rpm_t;

endpackage

>>> rtl/epmat_queue.sv
// ----------------------------------------------------------------------------
// epmat_queue
// Two-entry queue that carries updated averages from the front to the back.
// ----------------------------------------------------------------------------
module epmat_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  epmat_pkg::period_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output epmat_pkg::period_t out_data
);
    import epmat_pkg::*;

    period_t    mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Storage is written at the write pointer.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> rtl/epmat_front.sv
// ----------------------------------------------------------------------------
// epmat_front
// Takes edge beats, rejects glitches, and updates the period ring and the
// running average; each new average is handed to the queue.
// ----------------------------------------------------------------------------
module epmat_front #(
    parameter int WINDOW = 3
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [epmat_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [epmat_pkg::MINP_W-1:0] cfg_data,
    output logic                      q_valid,
    input  logic                      q_ready,
    output epmat_pkg::period_t        q_data
);
    import epmat_pkg::*;

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SHIFT_L = $clog2(WINDOW);
    localparam int PROD_W  = 2 * TIME_W;
    localparam int SUM_W   = PROD_W + 1;

    // Reciprocal of the window length, rounded up, scaled by 2^(32+SHIFT_L).
    // It needs 33 bits: the low 32 go through the multiplier and the top bit
    // adds the period shifted up by 32.
    localparam logic [63:0] RECIP =
        ((64'd1 << (TIME_W + SHIFT_L)) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam period_t RECIP_LO = RECIP[TIME_W-1:0];
    localparam logic    RECIP_HI = RECIP[TIME_W];

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_QUO  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [MINP_W-1:0] min_period_reg;
    period_t           last_edge_reg, last_edge_next;
    period_t           work_reg, work_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    period_t           avg_reg, avg_next;
    period_t           ring_reg [WINDOW];

    period_t           period;
    logic              accept;
    logic              keep;
    logic [SUM_W-1:0]  scaled;
    period_t           quotient;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign period    = s_tdata - last_edge_reg;
    assign keep      = (period > {{(TIME_W-MINP_W){1'b0}}, min_period_reg});
    assign q_valid   = (state_reg == ST_PUSH);
    assign q_data    = avg_reg;

    // Divide by the window length: full reciprocal product, then shift.
    assign scaled   = {1'b0, prod_reg}
                    + {1'b0, work_reg & {TIME_W{RECIP_HI}}, {TIME_W{1'b0}}};
    assign quotient = period_t'(scaled >> (TIME_W + SHIFT_L));

    // Next-state logic of the sequencer.
    always_comb begin
        state_next     = state_reg;
        last_edge_next = last_edge_reg;
        work_next      = work_reg;
        prod_next      = prod_reg;
        slot_next      = slot_reg;
        avg_next       = avg_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && keep) begin
                    last_edge_next = s_tdata;
                    work_next      = period;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(work_reg) * PROD_W'(RECIP_LO);
                state_next = ST_QUO;
            end
            ST_QUO: begin
                work_next  = quotient;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                // Work register now holds the new period divided by the window.
                avg_next = avg_reg - ring_reg[slot_reg] + work_reg;
                if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                    slot_next = '0;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (q_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            min_period_reg <= MINP_RESET;
            last_edge_reg  <= '0;
            slot_reg       <= '0;
            avg_reg        <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            last_edge_reg <= last_edge_next;
            slot_reg      <= slot_next;
            avg_reg       <= avg_next;
            if (cfg_valid && cfg_ready) begin
                min_period_reg <= cfg_data;
            end
            if (state_reg == ST_UPD) begin
                ring_reg[slot_reg] <= work_reg;
            end
        end
    end

    // Divider datapath registers.
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        prod_reg <= prod_next;
    end

endmodule

>>> rtl/epmat_back.sv
// ----------------------------------------------------------------------------
// epmat_back
// Divides the minute constant by each queued average and drives the result
// beats through an output register.
// ----------------------------------------------------------------------------
module epmat_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  epmat_pkg::period_t        q_data,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [epmat_pkg::M_TDATA_W-1:0] m_tdata
);
    import epmat_pkg::*;

    localparam int CNT_W = $clog2(RPM_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    rpm_t              num_reg, num_next;
    period_t           rem_reg, rem_next;
    period_t           den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_tvalid_reg;
    rpm_t              rpm_out_reg;
    period_t           avg_out_reg;

    logic [TIME_W:0]   rem_shift;
    logic              q_bit;
    logic              load_out;

    assign q_ready  = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-TIME_W-RPM_W){1'b0}}, avg_out_reg, rpm_out_reg};

    // One restoring step of the speed divide.
    assign rem_shift = {rem_reg, num_reg[RPM_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, den_reg});

    // Next-state logic of the divider sequencer.
    always_comb begin
        state_next = state_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    den_next = q_data;
                    rem_next = '0;
                    cnt_next = '0;
                    if (q_data == '0) begin
                        // A zero average reads as standstill.
                        num_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        num_next   = RPM_NUM;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next = q_bit ? TIME_W'(rem_shift - {1'b0, den_reg})
                                 : TIME_W'(rem_shift);
                num_next = {num_reg[RPM_W-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RPM_W - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (load_out) begin
            rpm_out_reg <= num_reg;
            avg_out_reg <= den_reg;
        end
    end

endmodule

>>> rtl/edge_period_moving_average_tach.sv
// ----------------------------------------------------------------------------
// edge_period_moving_average_tach
// Tachometer that averages sensor edge periods and reports speed in rpm.
// ----------------------------------------------------------------------------
// Each input beat is the microsecond timestamp of one sensor edge. An edge
// that follows the last kept edge by no more than min_period_us is dropped
// and gives no output. A kept edge passes through the front's states in
// order: IDLE takes it, MUL and QUO divide it by WINDOW as a multiply by its
// reciprocal, UPD updates the ring and average, and PUSH hands the average
// on. The back then takes the average, runs 26 quotient steps of the rpm
// divide (skipped when the average is zero) and loads the output register;
// it takes no new average before that load, so the rpm divide bounds the
// sustained rate of kept edges. A two-entry queue lets the front run ahead;
// once it is full the front holds s_tready low. Each output beat carries the
// speed and the new average period. WINDOW may range from 1 to 16.
module edge_period_moving_average_tach #(
    parameter int WINDOW = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Edge input; tdata: [31:0] edge_time_us.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Minimum-period register write; data: [23:0] min_period_us.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    // Result output; tdata: [25:0] rpm, [57:26] average period, [63:58] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata
);
    import epmat_pkg::*;

    logic    fq_valid;
    logic    fq_ready;
    period_t fq_data;
    logic    qb_valid;
    logic    qb_ready;
    period_t qb_data;

    // Edge classification and average update.
    epmat_front #(
        .WINDOW(WINDOW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    // Decoupling queue between the two halves.
    epmat_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // Speed divide and output register.
    epmat_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
